FILE: src/wrcs_pkg.sv
// ----------------------------------------------------------------------------
// wrcs_pkg
// Shared types and constants for the request capability sniffer.
// ----------------------------------------------------------------------------
package wrcs_pkg;

  localparam int MAX_FRAME_LEN = 4095;
  localparam int POS_W         = $clog2(MAX_FRAME_LEN + 1);
  localparam int CFG_IDX_W     = 4;
  localparam int MAC_W         = 48;
  localparam int FLAGS_W       = 4;
  localparam int OUT_DATA_W    = ((MAC_W + FLAGS_W + 7) / 8) * 8;

  localparam logic [7:0] TYPE_BITS    = 8'h0C;
  localparam logic [7:0] SUBTYPE_BITS = 8'hF0;
  localparam logic [7:0] SUB_PROBE    = 8'h40;
  localparam logic [7:0] SUB_ASSOC    = 8'h00;

  localparam logic [POS_W-1:0] PROBE_START = POS_W'(24);
  localparam logic [POS_W-1:0] ASSOC_START = POS_W'(28);
  localparam logic [POS_W-1:0] SA_FIRST    = POS_W'(10);
  localparam logic [POS_W-1:0] SA_LAST     = POS_W'(15);
  localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_FRAME_LEN);

  localparam logic [7:0] HE_MIN_LEN  = 8'd25;
  localparam logic [7:0] EHT_MIN_LEN = 8'd20;

  // Association body tests: octet index and bit mask per slot
  localparam logic [7:0] RM_OCT  = 8'd1;
  localparam logic [7:0] MD_OCT  = 8'd2;
  localparam logic [7:0] EXT_OCT = 8'd3;
  localparam logic [7:0] RSN_OCT = 8'd18;
  localparam logic [7:0] RM_MASK  = 8'h02;
  localparam logic [7:0] MD_MASK  = 8'h01;
  localparam logic [7:0] EXT_MASK = 8'h08;
  localparam logic [7:0] RSN_MASK = 8'h20;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_ASSOC = 2'd1,
    KIND_NONE  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDENT = 2'd0,
    PH_LEN   = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    SLOT_0    = 3'd0,
    SLOT_1    = 3'd1,
    SLOT_2    = 3'd2,
    SLOT_3    = 3'd3,
    SLOT_NONE = 3'd4
  } slot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ID_HT   = 4'd0,
    REG_ID_VHT  = 4'd1,
    REG_ID_HE   = 4'd2,
    REG_ID_EHT  = 4'd3,
    REG_ID_RM   = 4'd4,
    REG_ID_MD   = 4'd5,
    REG_ID_EXT  = 4'd6,
    REG_ID_RSN  = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] ht;
    logic [7:0] vht;
    logic [7:0] he;
    logic [7:0] eht;
    logic [7:0] rm;
    logic [7:0] md;
    logic [7:0] ext;
    logic [7:0] rsn;
  } ids_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic               kind;
    logic [MAC_W-1:0]   mac;
    logic [FLAGS_W-1:0] flags;
  } result_t;

endpackage

FILE: src/wlan_request_capability_sniffer.sv
// ----------------------------------------------------------------------------
// wlan_request_capability_sniffer
// Top level: captures probe and association requests byte by byte, walks
// their elements and reports source address plus four capability flags.
// ----------------------------------------------------------------------------
// Throughput: one frame byte per cycle, including across frames, unless a last byte waits on a full result register.
// After the last byte (s_tlast) is accepted, the result beat reaches m_tvalid
//   through the input register and the result register: the parser works on
//   it straight out of the input register and the result register loads it.
// A pending result does not block the stream; only a last byte waits while
//   the result register is still full.
// Reset (rst, synchronous) empties both stages, clears the frame state and
//   loads the default element identifiers.
module wlan_request_capability_sniffer (
  input  logic                            clk,
  input  logic                            rst,
  // Byte stream in
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] data_byte
  input  logic                            s_tlast,   // frame_end
  // Result out
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wrcs_pkg::OUT_DATA_W-1:0] m_tdata,   // [47:0] source_mac,
                                                     // [51:48] cap_flags, rest 0
  output logic [0:0]                      m_tuser,   // [0] frame_kind
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [wrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                      cfg_data
);
  import wrcs_pkg::*;

  ids_t    ids;
  beat_t   beat;
  result_t res;
  logic    take;
  logic    res_valid;
  logic    out_free;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  wrcs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ids       (ids)
  );

  // Hold each accepted beat until the parser consumes it
  wrcs_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .take     (take),
    .beat     (beat)
  );

  // Advance frame state; a last byte also needs room in the result register
  wrcs_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .ids       (ids),
    .beat      (beat),
    .out_free  (out_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  wrcs_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

FILE: src/wrcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// wrcs_cfg_regs
// Element identifier registers, written through the configuration channel.
// ----------------------------------------------------------------------------
module wrcs_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  input  logic [wrcs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                     cfg_data,
  output wrcs_pkg::ids_t                 ids
);
  import wrcs_pkg::*;

  ids_t ids_next;

  always_comb begin
    ids_next = ids;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ID_HT:  ids_next.ht  = cfg_data;
        REG_ID_VHT: ids_next.vht = cfg_data;
        REG_ID_HE:  ids_next.he  = cfg_data;
        REG_ID_EHT: ids_next.eht = cfg_data;
        REG_ID_RM:  ids_next.rm  = cfg_data;
        REG_ID_MD:  ids_next.md  = cfg_data;
        REG_ID_EXT: ids_next.ext = cfg_data;
        REG_ID_RSN: ids_next.rsn = cfg_data;
        default:    ids_next = ids;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ids <= '{ht: 8'd45, vht: 8'd191, he: 8'd35, eht: 8'd108,
               rm: 8'd70, md: 8'd54, ext: 8'd127, rsn: 8'd48};
    end else begin
      ids <= ids_next;
    end
  end

endmodule

FILE: src/wrcs_in_stage.sv
// ----------------------------------------------------------------------------
// wrcs_in_stage
// Input register: capture one byte beat, hold it until the parser takes it.
// ----------------------------------------------------------------------------
module wrcs_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  input  logic [7:0]      s_tdata,
  input  logic            s_tlast,
  input  logic            take,
  output wrcs_pkg::beat_t beat
);
  import wrcs_pkg::*;

  logic accept;

  assign s_tready = !beat.valid || take;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat.valid <= 1'b0;
    end else if (accept) begin
      beat.valid <= 1'b1;
    end else if (take) begin
      beat.valid <= 1'b0;
    end
    if (accept) begin
      beat.data <= s_tdata;
      beat.last <= s_tlast;
    end
  end

endmodule

FILE: src/wrcs_parser.sv
// ----------------------------------------------------------------------------
// wrcs_parser
// Per-frame state: header capture, element walk and flag commit.
// ----------------------------------------------------------------------------
module wrcs_parser (
  input  logic              clk,
  input  logic              rst,
  input  wrcs_pkg::ids_t    ids,
  input  wrcs_pkg::beat_t   beat,
  input  logic              out_free,
  output logic              take,
  output logic              res_valid,
  output wrcs_pkg::result_t res
);
  import wrcs_pkg::*;

  logic [POS_W-1:0]   byte_position, byte_position_next;
  logic [7:0]         frame_control, frame_control_next;
  logic [MAC_W-1:0]   source_address, source_address_next;
  phase_t             element_phase, element_phase_next;
  logic [7:0]         element_ident, element_ident_next;
  logic [7:0]         element_length, element_length_next;
  logic [7:0]         body_index, body_index_next;
  logic               pending_hit, pending_hit_next;
  logic [FLAGS_W-1:0] committed_flags, committed_flags_next;
  logic               walk_stopped, walk_stopped_next;

  logic [7:0]         b;
  logic [7:0]         fc;
  kind_t              kind;
  logic [POS_W-1:0]   start;
  logic               sat;
  logic               stopped;
  logic               walk_en;
  slot_t              slot;
  logic               hit;
  logic               body_done;
  logic               long_enough;
  logic [MAC_W-1:0]   sa_upd;
  logic [FLAGS_W-1:0] flags_upd;

  function automatic slot_t slot_of(input kind_t k, input logic [7:0] id, input ids_t r);
    slot_t s;
    s = SLOT_NONE;
    if (k == KIND_PROBE) begin
      if      (id == r.ht)  s = SLOT_0;
      else if (id == r.vht) s = SLOT_1;
      else if (id == r.he)  s = SLOT_2;
      else if (id == r.eht) s = SLOT_3;
    end else begin
      if      (id == r.rm)  s = SLOT_0;
      else if (id == r.md)  s = SLOT_1;
      else if (id == r.ext) s = SLOT_2;
      else if (id == r.rsn) s = SLOT_3;
    end
    return s;
  endfunction

  assign b    = beat.data;
  assign take = beat.valid && (!beat.last || out_free);
  assign fc   = (byte_position == '0) ? b : frame_control;

  always_comb begin
    if ((fc & TYPE_BITS) != 8'h00)            kind = KIND_NONE;
    else if ((fc & SUBTYPE_BITS) == SUB_PROBE) kind = KIND_PROBE;
    else if ((fc & SUBTYPE_BITS) == SUB_ASSOC) kind = KIND_ASSOC;
    else                                       kind = KIND_NONE;
  end

  assign start       = (kind == KIND_PROBE) ? PROBE_START : ASSOC_START;
  assign sat         = (byte_position >= POS_MAX);
  assign stopped     = walk_stopped || sat;
  assign walk_en     = (kind != KIND_NONE) && !stopped && (byte_position >= start);
  assign slot        = slot_of(kind, element_ident, ids);
  assign body_done   = ({1'b0, body_index} + 9'd1) >= {1'b0, element_length};
  assign long_enough = ({1'b0, byte_position} + (POS_W+1)'(1)) >= {1'b0, start};
  assign sa_upd      = (byte_position >= SA_FIRST && byte_position <= SA_LAST) ?
                       {source_address[MAC_W-9:0], b} : source_address;

  always_comb begin
    byte_position_next   = byte_position;
    frame_control_next   = frame_control;
    source_address_next  = source_address;
    element_phase_next   = element_phase;
    element_ident_next   = element_ident;
    element_length_next  = element_length;
    body_index_next      = body_index;
    pending_hit_next     = pending_hit;
    committed_flags_next = committed_flags;
    walk_stopped_next    = walk_stopped;
    flags_upd            = committed_flags;
    hit                  = 1'b0;
    res_valid            = 1'b0;

    if (take) begin
      frame_control_next  = fc;
      source_address_next = sa_upd;
      walk_stopped_next   = stopped;

      if (walk_en) begin
        unique case (element_phase)
          PH_LEN: begin
            element_length_next = b;
            body_index_next     = 8'd0;
            if (kind == KIND_PROBE) begin
              case (slot)
                SLOT_0, SLOT_1: hit = 1'b1;
                SLOT_2:         hit = (b >= HE_MIN_LEN);
                SLOT_3:         hit = (b >= EHT_MIN_LEN);
                default:        hit = 1'b0;
              endcase
            end
            if (b == 8'd0) begin
              if (slot != SLOT_NONE && hit) flags_upd[slot[1:0]] = 1'b1;
              pending_hit_next   = 1'b0;
              element_phase_next = PH_IDENT;
            end else begin
              pending_hit_next   = hit;
              element_phase_next = PH_BODY;
            end
          end
          PH_BODY: begin
            hit = pending_hit;
            if (kind == KIND_ASSOC) begin
              case (slot)
                SLOT_0: if (body_index == RM_OCT  && (b & RM_MASK)  != 8'h00) hit = 1'b1;
                SLOT_1: if (body_index == MD_OCT  && (b & MD_MASK)  != 8'h00) hit = 1'b1;
                SLOT_2: if (body_index == EXT_OCT && (b & EXT_MASK) != 8'h00) hit = 1'b1;
                SLOT_3: if (body_index == RSN_OCT && (b & RSN_MASK) != 8'h00) hit = 1'b1;
                default: ;
              endcase
            end
            if (body_done) begin
              if (slot != SLOT_NONE && hit) flags_upd[slot[1:0]] = 1'b1;
              pending_hit_next   = 1'b0;
              element_phase_next = PH_IDENT;
            end else begin
              pending_hit_next = hit;
              body_index_next  = body_index + 8'd1;
            end
          end
          default: begin
            element_ident_next = b;
            element_phase_next = PH_LEN;
          end
        endcase
      end
      committed_flags_next = flags_upd;

      if (!sat) byte_position_next = byte_position + POS_W'(1);

      if (beat.last) begin
        res_valid            = (kind != KIND_NONE) && long_enough;
        byte_position_next   = '0;
        frame_control_next   = 8'd0;
        source_address_next  = '0;
        element_phase_next   = PH_IDENT;
        element_ident_next   = 8'd0;
        element_length_next  = 8'd0;
        body_index_next      = 8'd0;
        pending_hit_next     = 1'b0;
        committed_flags_next = '0;
        walk_stopped_next    = 1'b0;
      end
    end
  end

  assign res.kind  = kind[0];
  assign res.mac   = sa_upd;
  assign res.flags = flags_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      frame_control   <= 8'd0;
      source_address  <= '0;
      element_phase   <= PH_IDENT;
      element_ident   <= 8'd0;
      element_length  <= 8'd0;
      body_index      <= 8'd0;
      pending_hit     <= 1'b0;
      committed_flags <= '0;
      walk_stopped    <= 1'b0;
    end else begin
      byte_position   <= byte_position_next;
      frame_control   <= frame_control_next;
      source_address  <= source_address_next;
      element_phase   <= element_phase_next;
      element_ident   <= element_ident_next;
      element_length  <= element_length_next;
      body_index      <= body_index_next;
      pending_hit     <= pending_hit_next;
      committed_flags <= committed_flags_next;
      walk_stopped    <= walk_stopped_next;
    end
  end

endmodule

FILE: src/wrcs_out_stage.sv
// ----------------------------------------------------------------------------
// wrcs_out_stage
// Result register: hold one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module wrcs_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            res_valid,
  input  wrcs_pkg::result_t               res,
  output logic                            out_free,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [wrcs_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [0:0]                      m_tuser
);
  import wrcs_pkg::*;

  result_t held;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign m_tdata = {(OUT_DATA_W - FLAGS_W - MAC_W)'(0), held.flags, held.mac};
  assign m_tuser = held.kind;

endmodule

FILE: src/wrcs_checker.sv
// ----------------------------------------------------------------------------
// wrcs_checker
// Port-level checks for the request capability sniffer.
// ----------------------------------------------------------------------------
module wrcs_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tready,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [wrcs_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic [0:0]                      m_tuser
);
  import wrcs_pkg::*;

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // Input backpressure only comes from a full result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !$past(rst))
    else $error("input stalled without a waiting result");

  // Nothing is presented right after reset
  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  // Padding bits above the flags stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:MAC_W+FLAGS_W] == '0)
    else $error("nonzero padding in result beat");

endmodule

bind wlan_request_capability_sniffer wrcs_checker u_wrcs_checker (.*);

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the request capability sniffer. A table of
// hand-built frames opens the run, then random probe and association
// requests follow under several element identifier settings. Every accepted
// byte goes through a local model of the parser, and every result beat is
// compared field by field against the oldest predicted report.
// ----------------------------------------------------------------------------
module testbench;
  import wrcs_pkg::*;

  localparam int  SETTLE_CYCLES = 8;       // pipeline is two deep, leave margin
  localparam int  HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int  NUM_PHASES    = 7;
  localparam int  PHASE_BYTES   = 265;     // about 1850 random bytes overall
  // Worst case is roughly 7k bytes, each behind the longest sender gap and a
  // stalled result. TIMEOUT_NS is set well above that worst case.
  localparam longint TIMEOUT_NS = 64'd16_000_000;

  localparam ids_t RESET_IDS = '{ht: 8'd45, vht: 8'd191, he: 8'd35, eht: 8'd108,
                                 rm: 8'd70, md: 8'd54, ext: 8'd127, rsn: 8'd48};
  localparam ids_t DUP_IDS   = '{ht: 8'd45, vht: 8'd45, he: 8'd45, eht: 8'd45,
                                 rm: 8'd70, md: 8'd70, ext: 8'd70, rsn: 8'd70};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_RHYTHM} rx_mode_t;

  // One hand-built frame: header, up to two elements with a run of zero
  // bytes between them, then trimmed from the end and/or given a lone byte.
  // Rows marked typed carry their report; the rest go to the model.
  typedef struct packed {
    logic               typed;
    logic               has;
    logic               kind;
    logic [FLAGS_W-1:0] flags;
    logic               dup;     // needs the duplicate identifier setting
    logic [7:0]         fc;
    logic [MAC_W-1:0]   mac;
    logic [5:0]         hdr;
    logic [1:0]         n_el;
    logic [7:0]         id0;
    logic [7:0]         len0;
    logic [7:0]         fill0;
    logic [12:0]        pad;
    logic [7:0]         id1;
    logic [7:0]         len1;
    logic [7:0]         fill1;
    logic [7:0]         cut;
    logic               lone;
  } dir_frame_t;

  typedef struct packed {
    logic    typed;
    logic    has;
    result_t r;
  } table_verdict_t;

  localparam int NUM_ROWS = 21;
  // typed has kind flags dup | fc mac hdr n_el | id0 len0 fill0 | pad |
  // id1 len1 fill1 | cut lone
  localparam dir_frame_t FRAME_TABLE [NUM_ROWS] = '{
    // probe cut to 10 bytes: too short
    '{1, 0, 0, 0, 0, 8'h40, 48'h0, 24, 0, 0, 0, 0, 0, 0, 0, 0, 14, 0},
    // bare probe header
    '{1, 1, 0, 0, 0, 8'h40, 48'h0123_4567_89AB, 24, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // HT of length zero commits on its length byte
    '{1, 1, 0, 1, 0, 8'h40, 48'hFFFF_FFFF_FFFF, 24, 1, 45, 0, 0, 0, 0, 0, 0, 0, 0},
    // data frame: type bits set
    '{1, 0, 0, 0, 0, 8'h08, 48'h0, 28, 1, 45, 0, 0, 0, 0, 0, 0, 0, 0},
    // bare association header
    '{1, 1, 1, 0, 0, 8'h00, 48'h0, 28, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    // association one byte short
    '{1, 0, 0, 0, 0, 8'h00, 48'h0, 28, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0},
    // all ones frame control
    '{1, 0, 0, 0, 0, 8'hFF, 48'hFFFF_FFFF_FFFF, 24, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 8'h43, 48'hA5A5_5A5A_0F0F, 24, 2, 45, 26, 8'hFF, 0, 191, 12, 8'h00, 0, 0},
    // HE at its minimum, EHT one short
    '{0, 0, 0, 0, 0, 8'h40, 48'h1122_3344_5566, 24, 2, 35, 25, 8'h5A, 0, 108, 19, 8'hC3, 0, 0},
    // HE one short, EHT at its minimum
    '{0, 0, 0, 0, 0, 8'h41, 48'h6655_4433_2211, 24, 2, 35, 24, 8'h3C, 0, 108, 20, 8'h96, 0, 0},
    // truncated VHT
    '{0, 0, 0, 0, 0, 8'h40, 48'h8000_0000_0001, 24, 1, 191, 10, 8'h11, 0, 0, 0, 0, 3, 0},
    // trailing lone identifier
    '{0, 0, 0, 0, 0, 8'h40, 48'h0000_0000_0080, 24, 1, 45, 0, 0, 0, 0, 0, 0, 0, 1},
    '{0, 0, 0, 0, 0, 8'h03, 48'hDEAD_BEEF_CAFE, 28, 2, 70, 5, 8'h02, 0, 54, 3, 8'h01, 0, 0},
    '{0, 0, 0, 0, 0, 8'h00, 48'h0A0B_0C0D_0E0F, 28, 2, 127, 4, 8'h08, 0, 48, 19, 8'h20, 0, 0},
    // RSN too short for its octet, ext cap missing octet 3
    '{0, 0, 0, 0, 0, 8'h02, 48'hF0F0_F0F0_F0F0, 28, 2, 48, 18, 8'hFF, 0, 127, 3, 8'hFF, 0, 0},
    // longest element, then mobility domain of length zero
    '{0, 0, 0, 0, 0, 8'h01, 48'h0F0F_0F0F_0F0F, 28, 2, 70, 255, 8'h02, 0, 54, 0, 0, 0, 0},
    // past the saturation point: the late VHT must not count
    '{0, 0, 0, 0, 0, 8'h40, 48'h1357_9BDF_0246, 24, 2, 45, 0, 0, 4100, 191, 0, 0, 0, 0},
    // unknown management subtype
    '{0, 0, 0, 0, 0, 8'h50, 48'h2468_ACE0_1357, 28, 1, 70, 5, 8'hFF, 0, 0, 0, 0, 0, 0},
    // single byte frame
    '{1, 0, 0, 0, 0, 8'h40, 48'h0, 24, 0, 0, 0, 0, 0, 0, 0, 0, 23, 0},
    // equal identifiers: first register in the order wins
    '{0, 0, 0, 0, 1, 8'h40, 48'h7777_8888_9999, 24, 1, 45, 30, 8'hFF, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 1, 8'h00, 48'h9999_8888_7777, 28, 1, 70, 19, 8'hFF, 0, 0, 0, 0, 0, 0}
  };

  // DUT connections; drive every input to a known value from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata   = 8'h00;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [0:0]            m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_ID_HT;
  logic [7:0]            cfg_data  = 8'h00;

  // Parser model state
  logic [POS_W-1:0]   cap_pos;
  logic [7:0]         cap_fc;
  logic [MAC_W-1:0]   cap_sa;
  phase_t             cap_phase;
  logic [7:0]         cap_ident;
  logic [7:0]         cap_len;
  logic [7:0]         cap_bidx;
  logic               cap_pend;
  logic [FLAGS_W-1:0] cap_flags;
  logic               cap_stop;
  ids_t               cap_ids;

  result_t        pending_reports [$];
  table_verdict_t table_verdicts [$];
  logic [7:0]     frame_buf [$];
  ids_t           gen_ids;
  int             errors      = 0;
  int             sent_bytes  = 0;
  int             burst_left  = 0;
  int             hold_ask    = 0;
  int             hold_seen   = 0;
  int             hold_left   = 0;
  int             rx_left     = 0;
  int             rx_tick     = 0;
  rx_mode_t       rx_mode     = RX_OPEN;

  wlan_request_capability_sniffer uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Parser model
  // --------------------------------------------------------------------------
  function automatic kind_t kind_of(logic [7:0] fc);
    if ((fc & TYPE_BITS) != 8'h00) return KIND_NONE;
    if ((fc & SUBTYPE_BITS) == SUB_PROBE) return KIND_PROBE;
    if ((fc & SUBTYPE_BITS) == SUB_ASSOC) return KIND_ASSOC;
    return KIND_NONE;
  endfunction

  // Map an identifier to its flag slot; the first matching register wins
  function automatic slot_t slot_of(kind_t k, logic [7:0] id, ids_t ids);
    if (k == KIND_PROBE) begin
      if (id == ids.ht)  return SLOT_0;
      if (id == ids.vht) return SLOT_1;
      if (id == ids.he)  return SLOT_2;
      if (id == ids.eht) return SLOT_3;
    end else begin
      if (id == ids.rm)  return SLOT_0;
      if (id == ids.md)  return SLOT_1;
      if (id == ids.ext) return SLOT_2;
      if (id == ids.rsn) return SLOT_3;
    end
    return SLOT_NONE;
  endfunction

  task automatic clear_capture();
    cap_pos   = '0;
    cap_fc    = '0;
    cap_sa    = '0;
    cap_phase = PH_IDENT;
    cap_ident = '0;
    cap_len   = '0;
    cap_bidx  = '0;
    cap_pend  = 1'b0;
    cap_flags = '0;
    cap_stop  = 1'b0;
  endtask

  // Close the current element: its flag counts only if the hit is pending
  task automatic close_element(slot_t s);
    if (s != SLOT_NONE && cap_pend) cap_flags = cap_flags | (FLAGS_W'(1) << s);
    cap_pend  = 1'b0;
    cap_phase = PH_IDENT;
  endtask

  task automatic walk_element(kind_t k, logic [7:0] b);
    slot_t s;
    case (cap_phase)
      PH_LEN: begin
        cap_len  = b;
        cap_bidx = '0;
        cap_pend = 1'b0;
        s = slot_of(k, cap_ident, cap_ids);
        if (k == KIND_PROBE) begin
          if (s == SLOT_0 || s == SLOT_1) cap_pend = 1'b1;
          else if (s == SLOT_2) cap_pend = (b >= HE_MIN_LEN);
          else if (s == SLOT_3) cap_pend = (b >= EHT_MIN_LEN);
        end
        if (b == 8'h00) close_element(s);
        else cap_phase = PH_BODY;
      end
      PH_BODY: begin
        s = slot_of(k, cap_ident, cap_ids);
        if (k == KIND_ASSOC) begin
          if ((s == SLOT_0 && cap_bidx == RM_OCT  && (b & RM_MASK)  != 8'h00) ||
              (s == SLOT_1 && cap_bidx == MD_OCT  && (b & MD_MASK)  != 8'h00) ||
              (s == SLOT_2 && cap_bidx == EXT_OCT && (b & EXT_MASK) != 8'h00) ||
              (s == SLOT_3 && cap_bidx == RSN_OCT && (b & RSN_MASK) != 8'h00))
            cap_pend = 1'b1;
        end
        if (cap_bidx + 1 >= cap_len) close_element(s);
        else cap_bidx = cap_bidx + 8'd1;
      end
      default: begin
        cap_ident = b;
        cap_phase = PH_LEN;
      end
    endcase
  endtask

  // Advance the model by one frame byte; report on a qualifying last byte
  task automatic sniff_byte(input logic [7:0] b, input logic last,
                            output logic got, output result_t r);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] start;
    kind_t            k;
    p   = cap_pos;
    got = 1'b0;
    r   = '0;
    if (p == '0) cap_fc = b;
    if (p >= SA_FIRST && p <= SA_LAST) cap_sa = {cap_sa[MAC_W-9:0], b};
    k     = kind_of(cap_fc);
    start = (k == KIND_PROBE) ? PROBE_START : ASSOC_START;
    if (p >= POS_MAX) cap_stop = 1'b1;
    if (k != KIND_NONE && !cap_stop && p >= start) walk_element(k, b);
    if (p < POS_MAX) cap_pos = p + 1'b1;
    if (last) begin
      if (k != KIND_NONE && p + 1 >= start) begin
        r.kind  = (k == KIND_ASSOC);
        r.mac   = cap_sa;
        r.flags = cap_flags;
        got     = 1'b1;
      end
      clear_capture();
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: follow config writes, predict on input beats, check result beats
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    logic           got;
    result_t        r;
    result_t        want;
    table_verdict_t tv;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ID_HT:  cap_ids.ht  = cfg_data;
          REG_ID_VHT: cap_ids.vht = cfg_data;
          REG_ID_HE:  cap_ids.he  = cfg_data;
          REG_ID_EHT: cap_ids.eht = cfg_data;
          REG_ID_RM:  cap_ids.rm  = cfg_data;
          REG_ID_MD:  cap_ids.md  = cfg_data;
          REG_ID_EXT: cap_ids.ext = cfg_data;
          REG_ID_RSN: cap_ids.rsn = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        sniff_byte(s_tdata, s_tlast, got, r);
        if (s_tlast) begin
          // Typed table rows override the model for their frame
          if (table_verdicts.size() != 0) begin
            tv = table_verdicts.pop_front();
            if (tv.typed) begin
              got = tv.has;
              r   = tv.r;
            end
          end
          if (got) pending_reports.push_back(r);
        end
      end
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          $error("result beat with no report pending: frame_kind %0d source_mac %h cap_flags %h",
                 m_tuser[0], m_tdata[MAC_W-1:0], m_tdata[MAC_W +: FLAGS_W]);
          errors++;
        end else begin
          want = pending_reports.pop_front();
          if (m_tuser[0] !== want.kind) begin
            $error("frame_kind: expected %0d, actual %0d", want.kind, m_tuser[0]);
            errors++;
          end
          if (m_tdata[MAC_W-1:0] !== want.mac) begin
            $error("source_mac: expected %h, actual %h", want.mac, m_tdata[MAC_W-1:0]);
            errors++;
          end
          if (m_tdata[MAC_W +: FLAGS_W] !== want.flags) begin
            $error("cap_flags: expected %h, actual %h", want.flags,
                   m_tdata[MAC_W +: FLAGS_W]);
            errors++;
          end
          if (m_tdata[OUT_DATA_W-1:MAC_W+FLAGS_W] !== '0) begin
            $error("tdata padding: expected 0, actual %h",
                   m_tdata[OUT_DATA_W-1:MAC_W+FLAGS_W]);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: pick a new pacing mode after each random run; on request hold off for a
  // long stretch so the single result register fills and the input stalls
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_ask != hold_seen) begin
      hold_seen = hold_ask;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 80);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
        RX_OPEN:   m_tready <= 1'b1;
        RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_tready <= ($urandom_range(0, 3) == 0);
        default:   m_tready <= (rx_tick % 3 != 2);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  // Offer one byte; between bursts drop valid for a random gap
  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap = 0;
        4, 5, 6, 7: gap = $urandom_range(1, 3);
        8:          gap = $urandom_range(4, 10);
        default:    gap = $urandom_range(11, 20);
      endcase
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_buf.size(); i++) push_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Hold the stream idle until every report is out and the pipeline is empty
  task automatic settle();
    s_tvalid <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [7:0] v);
    cfg_index <= idx;
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_ids(input ids_t v);
    write_reg(REG_ID_HT,  v.ht);
    write_reg(REG_ID_VHT, v.vht);
    write_reg(REG_ID_HE,  v.he);
    write_reg(REG_ID_EHT, v.eht);
    write_reg(REG_ID_RM,  v.rm);
    write_reg(REG_ID_MD,  v.md);
    write_reg(REG_ID_EXT, v.ext);
    write_reg(REG_ID_RSN, v.rsn);
    gen_ids = v;
  endtask

  // Build a random frame: mostly well-formed requests whose element ids come
  // from the current setting, with some noise, truncation and lone bytes
  task automatic gen_frame();
    int         sel;
    int         n_el;
    int         i;
    int         j;
    int         len;
    int         hdr;
    slot_t      pick;
    logic [7:0] fc;
    logic [7:0] id;
    kind_t      k;
    frame_buf.delete();
    sel = $urandom_range(0, 99);
    if (sel < 6) begin
      len = $urandom_range(1, 40);
      for (i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
      return;
    end
    if (sel < 50) fc = {4'h4, 2'b00, 2'($urandom)};
    else if (sel < 92) fc = {4'h0, 2'b00, 2'($urandom)};
    else fc = 8'($urandom);
    k   = kind_of(fc);
    hdr = (k == KIND_ASSOC) ? 28 : (k == KIND_PROBE) ? 24 : $urandom_range(24, 28);
    frame_buf.push_back(fc);
    for (i = 1; i < hdr; i++) frame_buf.push_back(8'($urandom));
    n_el = $urandom_range(0, 5);
    for (i = 0; i < n_el; i++) begin
      pick = slot_t'($urandom_range(0, 4));
      if (k == KIND_ASSOC) begin
        case (pick)
          SLOT_0:  id = gen_ids.rm;
          SLOT_1:  id = gen_ids.md;
          SLOT_2:  id = gen_ids.ext;
          SLOT_3:  id = gen_ids.rsn;
          default: id = 8'($urandom);
        endcase
      end else begin
        case (pick)
          SLOT_0:  id = gen_ids.ht;
          SLOT_1:  id = gen_ids.vht;
          SLOT_2:  id = gen_ids.he;
          SLOT_3:  id = gen_ids.eht;
          default: id = 8'($urandom);
        endcase
      end
      // Keep lengths near the thresholds and tested octets
      if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 255);
      else if (k == KIND_ASSOC) len = (pick == SLOT_3) ? $urandom_range(16, 22)
                                                       : $urandom_range(0, 6);
      else if (pick == SLOT_2) len = $urandom_range(22, 28);
      else if (pick == SLOT_3) len = $urandom_range(17, 23);
      else len = $urandom_range(0, 12);
      frame_buf.push_back(id);
      frame_buf.push_back(8'(len));
      for (j = 0; j < len; j++) frame_buf.push_back(8'($urandom));
    end
    case ($urandom_range(0, 9))
      0, 1: begin
        len = $urandom_range(1, 6);
        for (j = 0; j < len; j++) if (frame_buf.size() > 1) void'(frame_buf.pop_back());
      end
      2:       frame_buf.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int             i;
    int             ph;
    int             phase_start;
    logic           dup_on;
    dir_frame_t     row;
    table_verdict_t tv;
    ids_t           v;
    cap_ids = RESET_IDS;
    gen_ids = RESET_IDS;
    clear_capture();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table under the reset identifiers, then the duplicate setting for rows that need it
    dup_on = 1'b0;
    for (i = 0; i < NUM_ROWS; i++) begin
      row = FRAME_TABLE[i];
      if (row.dup && !dup_on) begin
        settle();
        load_ids(DUP_IDS);
        dup_on = 1'b1;
      end
      frame_buf.delete();
      frame_buf.push_back(row.fc);
      for (int h = 1; h < row.hdr; h++)
        frame_buf.push_back((h >= 10 && h <= 15) ? row.mac[8*(15-h) +: 8] : 8'(h));
      if (row.n_el >= 1) begin
        frame_buf.push_back(row.id0);
        frame_buf.push_back(row.len0);
        repeat (row.len0) frame_buf.push_back(row.fill0);
      end
      repeat (row.pad) frame_buf.push_back(8'h00);
      if (row.n_el >= 2) begin
        frame_buf.push_back(row.id1);
        frame_buf.push_back(row.len1);
        repeat (row.len1) frame_buf.push_back(row.fill1);
      end
      repeat (row.cut) void'(frame_buf.pop_back());
      if (row.lone) frame_buf.push_back(row.id0);
      tv.typed   = row.typed;
      tv.has     = row.has;
      tv.r.kind  = row.kind;
      tv.r.mac   = row.mac;
      tv.r.flags = row.flags;
      table_verdicts.push_back(tv);
      send_frame();
    end

    // Random frames, one identifier setting per phase
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      settle();
      case (ph)
        0: v = RESET_IDS;
        1: v = '0;
        2: v = '1;
        4: begin
          v     = {$urandom, $urandom};
          v.vht = v.ht;
          v.eht = v.he;
          v.md  = v.rm;
          v.rsn = v.ext;
        end
        default: v = {$urandom, $urandom};
      endcase
      load_ids(v);
      // Stall the receiver while the sender keeps pushing frames
      if (ph == 3) hold_ask++;
      phase_start = sent_bytes;
      while (sent_bytes - phase_start < PHASE_BYTES) begin
        gen_frame();
        send_frame();
      end
    end

    settle();
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("wlan_request_capability_sniffer verification clean");
    end else begin
      if (pending_reports.size() != 0)
        $error("%0d reports never arrived", pending_reports.size());
      $display("wlan_request_capability_sniffer verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("wlan_request_capability_sniffer verification failed");
    $finish;
  end

endmodule
